// ===== rtl/core/hcr_pkg.sv =====
// Shared types and codes for the handle table with clock replacement.
package hcr_pkg;

  localparam int ENTRIES_DEF    = 32;
  localparam int COUNT_BITS_DEF = 8;

  // request kinds
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_NO_VICT  = 2'd2;

  // register address of handle_limit
  localparam logic [1:0] ADDR_LIMIT = 2'd0;

  typedef enum logic [1:0] {
    ENT_EMPTY  = 2'd0,
    ENT_CLOSED = 2'd1,
    ENT_OPEN   = 2'd2
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SW_RD,
    S_SW_EV,
    S_WR_CUR,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] entry_index;
    logic [3:0] open_mode;
    logic       pinned_flag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       evicted_valid;
    logic [4:0] evicted_index;
    logic [5:0] open_total;
  } rsp_t;

endpackage

// ===== rtl/core/handle_clock_replacement_top.sv =====
// Top level: handle table with clock (second-chance) replacement.
//
// Each request reads its table entry from a single-port synchronous memory, updates it and
// writes it back; a request that needs no sweep goes from the execute state to the output
// state, which loads the result register once that register is free. Begin access on a
// closed entry with the table at its limit runs the clock sweep through the same memory
// port, each entry visited taking a read state and then an evaluate and write-back state,
// for up to two turns of the table, then a state to write the requested entry. Per-entry
// valid bits make the table read as empty after reset, so no clearing pass is needed. One
// request is in flight at a time; a new one is accepted while the previous result still
// waits in the output register.
module handle_clock_replacement_top #(
  parameter int ENTRIES    = hcr_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = hcr_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hcr_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hcr_pkg::rsp_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import hcr_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SW_W  = $clog2(2 * ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    ent_t                  st;
    logic [COUNT_BITS-1:0] refs;
    logic [COUNT_BITS-1:0] act;
    logic                  used;
    logic                  pin;
    logic [3:0]            mode;
  } rec_t;

  // table memory and per-entry valid bits
  rec_t               mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  rec_t               rd_q;
  logic               vld_q;

  logic            re, we;
  logic [IDX_W-1:0] ra, wa;
  rec_t            wd;

  fsm_t             state, state_next;
  req_t             req, req_next;
  rec_t             cur, cur_next;
  logic [IDX_W-1:0] hand, hand_next;
  logic [IDX_W-1:0] h, h_next;
  logic [SW_W-1:0]  steps, steps_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [5:0]       limit;
  logic [1:0]       res_st, res_st_next;
  logic             res_ev, res_ev_next;
  logic [IDX_W-1:0] res_ei, res_ei_next;
  logic             out_valid_next;
  rsp_t             out_data_next;

  rec_t             eff, nr;
  logic [IDX_W-1:0] addr, h_inc;
  logic             in_range, at_limit;
  logic [31:0]      ei_wide;

  // config port
  assign pready = 1'b1;
  assign prdata = {26'b0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_LIMIT) begin
      limit <= pwdata[5:0];
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[wa] <= 1'b1;
      end
      if (re) begin
        vld_q <= vld[ra];
      end
    end
  end

  assign eff      = vld_q ? rd_q : '0;
  assign addr     = IDX_W'(req.entry_index);
  assign in_range = 32'(req.entry_index) < ENTRIES;
  assign at_limit = 32'(cnt) >= 32'(limit);
  assign h_inc    = (32'(h) == ENTRIES - 1) ? '0 : h + 1'b1;
  assign ei_wide  = 32'(res_ei);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hand      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hand      <= hand_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    req      <= req_next;
    cur      <= cur_next;
    h        <= h_next;
    steps    <= steps_next;
    res_st   <= res_st_next;
    res_ev   <= res_ev_next;
    res_ei   <= res_ei_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    req_next       = req;
    cur_next       = cur;
    hand_next      = hand;
    h_next         = h;
    steps_next     = steps;
    cnt_next       = cnt;
    res_st_next    = res_st;
    res_ev_next    = res_ev;
    res_ei_next    = res_ei;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    re = 1'b0;
    ra = addr;
    we = 1'b0;
    wa = addr;
    wd = eff;
    nr = eff;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_data;
          re         = 1'b1;
          ra         = IDX_W'(in_data.entry_index);
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_st_next = STAT_OK;
        res_ev_next = 1'b0;
        res_ei_next = '0;
        state_next  = S_OUT;
        if (in_range) begin
          unique case (req.kind)
            KIND_OPEN: begin
              if (eff.st == ENT_EMPTY) begin
                nr.st    = ENT_OPEN;
                nr.refs  = COUNT_BITS'(1);
                nr.act   = '0;
                nr.used  = 1'b1;
                nr.pin   = req.pinned_flag;
                nr.mode  = req.open_mode;
                we       = 1'b1;
                cnt_next = cnt + 1'b1;
              end else if (eff.mode != req.open_mode || eff.pin != req.pinned_flag) begin
                res_st_next = STAT_MISMATCH;
              end else if (eff.refs != CMAX) begin
                nr.refs = eff.refs + 1'b1;
                we      = 1'b1;
              end
            end
            KIND_BEGIN: begin
              if (eff.st != ENT_EMPTY && limit != '0) begin
                if (eff.act != CMAX) begin
                  nr.act = eff.act + 1'b1;
                end
                nr.used = 1'b1;
                if (eff.st != ENT_OPEN && at_limit) begin
                  // defer the write until the sweep settles
                  cur_next   = nr;
                  h_next     = hand;
                  steps_next = '0;
                  state_next = S_SW_RD;
                end else begin
                  if (eff.st != ENT_OPEN) begin
                    nr.st    = ENT_OPEN;
                    cnt_next = cnt + 1'b1;
                  end
                  we = 1'b1;
                end
              end
            end
            KIND_END: begin
              if (eff.st != ENT_EMPTY && limit != '0 && eff.act != '0) begin
                nr.act = eff.act - 1'b1;
                we     = 1'b1;
              end
            end
            KIND_CLOSE: begin
              if (eff.st != ENT_EMPTY) begin
                if (eff.refs != '0) begin
                  nr.refs = eff.refs - 1'b1;
                end
                if (nr.refs == '0) begin
                  if (eff.st == ENT_OPEN && cnt != '0) begin
                    cnt_next = cnt - 1'b1;
                  end
                  nr.st   = ENT_EMPTY;
                  nr.act  = '0;
                  nr.used = 1'b0;
                end
                we = 1'b1;
              end
            end
            default: ;
          endcase
        end
        wd = nr;
      end

      S_SW_RD: begin
        re         = 1'b1;
        ra         = h;
        state_next = S_SW_EV;
      end

      S_SW_EV: begin
        wa = h;
        wd = eff;
        if (eff.st == ENT_OPEN && eff.act == '0 && !eff.pin && !eff.used) begin
          // victim found: close it and move the hand past it
          wd.st       = ENT_CLOSED;
          we          = 1'b1;
          if (cnt != '0) begin
            cnt_next = cnt - 1'b1;
          end
          hand_next   = h_inc;
          res_ev_next = 1'b1;
          res_ei_next = h;
          state_next  = S_WR_CUR;
        end else begin
          if (eff.st == ENT_OPEN && eff.act == '0 && !eff.pin) begin
            wd.used = 1'b0;
            we      = 1'b1;
          end
          h_next     = h_inc;
          steps_next = steps + 1'b1;
          if (steps == SW_W'(2 * ENTRIES - 1)) begin
            hand_next   = h_inc;
            res_st_next = STAT_NO_VICT;
            state_next  = S_WR_CUR;
          end else begin
            state_next = S_SW_RD;
          end
        end
      end

      S_WR_CUR: begin
        wd = cur;
        we = 1'b1;
        if (res_st == STAT_OK) begin
          wd.st    = ENT_OPEN;
          cnt_next = cnt + 1'b1;
        end
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next              = 1'b1;
          out_data_next.status        = res_st;
          out_data_next.evicted_valid = res_ev;
          out_data_next.evicted_index = ei_wide[4:0];
          out_data_next.open_total    = (32'(cnt) > 63) ? 6'd63 : 6'(cnt);
          state_next                  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= ENTRIES)
    else $error("open count exceeds table size");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted_valid |-> out_data.status == STAT_OK)
    else $error("eviction reported with failing status");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_RD || state == S_SW_EV) |-> 32'(steps) < 2 * ENTRIES)
    else $error("sweep ran past two turns");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_OUT) |-> !we)
    else $error("table write outside a request");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the handle table with clock replacement.
`timescale 1ns / 1ps

module testbench;
  import hcr_pkg::*;

  localparam int NENT = 32;
  localparam int CMAX = 255;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  handle_clock_replacement_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // table model
  ent_t      tbl_state [NENT];
  int        tbl_refs  [NENT];
  int        tbl_act   [NENT];
  bit        tbl_used  [NENT];
  bit        tbl_pin   [NENT];
  bit [3:0]  tbl_mode  [NENT];
  int        hand;
  int        open_cnt;
  int        limit_reg;

  rsp_t      pending_rsp [$];
  int        errors = 0;
  int        n_rsp = 0;
  int        n_evict = 0;
  int        n_novict = 0;
  int        cycles = 0;
  bit        hold_off = 1'b0;

  function automatic rsp_t predict_request(req_t r);
    rsp_t o;
    int idx, h;
    bit room, found;
    o = '0;
    idx = r.entry_index;
    case (r.kind)
      KIND_OPEN: begin
        if (tbl_state[idx] == ENT_EMPTY) begin
          tbl_state[idx] = ENT_OPEN;
          tbl_mode[idx] = r.open_mode;
          tbl_pin[idx] = r.pinned_flag;
          tbl_refs[idx] = 1;
          tbl_act[idx] = 0;
          tbl_used[idx] = 1'b1;
          open_cnt++;
        end else if (tbl_mode[idx] != r.open_mode || tbl_pin[idx] != r.pinned_flag) begin
          o.status = STAT_MISMATCH;
        end else if (tbl_refs[idx] < CMAX) begin
          tbl_refs[idx]++;
        end
      end
      KIND_BEGIN: begin
        if (tbl_state[idx] != ENT_EMPTY && limit_reg != 0) begin
          if (tbl_act[idx] < CMAX) tbl_act[idx]++;
          tbl_used[idx] = 1'b1;
          if (tbl_state[idx] != ENT_OPEN) begin
            room = 1'b1;
            if (open_cnt >= limit_reg) begin
              found = 1'b0;
              h = hand;
              for (int s = 0; s < 2 * NENT && !found; s++) begin
                if (tbl_state[h] == ENT_OPEN && tbl_act[h] == 0 && !tbl_pin[h]) begin
                  if (!tbl_used[h]) begin
                    tbl_state[h] = ENT_CLOSED;
                    if (open_cnt > 0) open_cnt--;
                    o.evicted_valid = 1'b1;
                    o.evicted_index = h[4:0];
                    found = 1'b1;
                  end else begin
                    tbl_used[h] = 1'b0;
                  end
                end
                h = (h + 1) % NENT;
              end
              hand = h;
              room = found;
              if (!found) o.status = STAT_NO_VICT;
            end
            if (room) begin
              tbl_state[idx] = ENT_OPEN;
              open_cnt++;
            end
          end
        end
      end
      KIND_END: begin
        if (tbl_state[idx] != ENT_EMPTY && limit_reg != 0 && tbl_act[idx] > 0)
          tbl_act[idx]--;
      end
      default: begin
        if (tbl_state[idx] != ENT_EMPTY) begin
          if (tbl_refs[idx] > 0) tbl_refs[idx]--;
          if (tbl_refs[idx] == 0) begin
            if (tbl_state[idx] == ENT_OPEN && open_cnt > 0) open_cnt--;
            tbl_state[idx] = ENT_EMPTY;
            tbl_act[idx] = 0;
            tbl_used[idx] = 1'b0;
          end
        end
      end
    endcase
    o.open_total = (open_cnt > 63) ? 6'd63 : open_cnt[5:0];
    return o;
  endfunction

  // hold valid after acceptance only until the next request or gap takes over
  task automatic send_request(req_t r, bit has_exp, rsp_t exp_rsp);
    rsp_t p;
    p = predict_request(r);
    if (has_exp && p !== exp_rsp) begin
      $display("%0t: table row disagrees with prediction: exp %h pred %h",
               $time, exp_rsp, p);
      errors++;
    end
    pending_rsp.push_back(p);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      release_input();
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    release_input();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4 * NENT + 20) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_LIMIT; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    limit_reg = v & 63;
    @(posedge clk);
  endtask

  // receiver: check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        n_rsp++;
        if (e.evicted_valid) n_evict++;
        if (e.status == STAT_NO_VICT) n_novict++;
        if (out_data.status !== e.status || out_data.evicted_valid !== e.evicted_valid ||
            out_data.evicted_index !== e.evicted_index ||
            out_data.open_total !== e.open_total) begin
          $display("%0t: result mismatch: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_ready <= 1'b0;
    else if ($urandom_range(0, 2) != 0) out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("handle_clock_replacement_top regression: fail");
      $finish;
    end
  end

  typedef struct {
    req_t r;
    bit   has_exp;
    rsp_t e;
  } row_t;

  function automatic req_t mk(logic [1:0] k, int i, int m, bit p);
    req_t r;
    r.kind = k; r.entry_index = i[4:0]; r.open_mode = m[3:0]; r.pinned_flag = p;
    return r;
  endfunction

  function automatic rsp_t ex(logic [1:0] s, bit v, int i, int t);
    rsp_t o;
    o.status = s; o.evicted_valid = v; o.evicted_index = i[4:0]; o.open_total = t[5:0];
    return o;
  endfunction

  function automatic req_t random_request(int span);
    req_t r;
    int m;
    r.entry_index = 5'($urandom_range(0, span - 1));
    m = $urandom_range(0, 9);
    r.kind = (m < 3) ? KIND_OPEN : (m < 6) ? KIND_BEGIN : (m < 8) ? KIND_END : KIND_CLOSE;
    // keep modes consistent with the stored one most of the time
    if (tbl_state[r.entry_index] != ENT_EMPTY && $urandom_range(0, 4) != 0) begin
      r.open_mode = tbl_mode[r.entry_index];
      r.pinned_flag = tbl_pin[r.entry_index];
    end else begin
      r.open_mode = 4'($urandom_range(0, 15));
      r.pinned_flag = ($urandom_range(0, 7) == 0);
    end
    return r;
  endfunction

  row_t dir_rows [$];

  initial begin
    int limits [6];
    limits = '{4, 1, 32, 0, 2, 8};
    for (int i = 0; i < NENT; i++) begin
      tbl_state[i] = ENT_EMPTY; tbl_refs[i] = 0; tbl_act[i] = 0;
      tbl_used[i] = 0; tbl_pin[i] = 0; tbl_mode[i] = '0;
    end
    hand = 0; open_cnt = 0; limit_reg = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limit is zero after reset: begin/end do nothing
    dir_rows.push_back('{mk(KIND_BEGIN, 0, 0, 0), 1, ex(STAT_OK, 0, 0, 0)});
    dir_rows.push_back('{mk(KIND_OPEN, 0, 15, 0), 1, ex(STAT_OK, 0, 0, 1)});
    dir_rows.push_back('{mk(KIND_OPEN, 31, 0, 1), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_OPEN, 0, 14, 0), 1, ex(STAT_MISMATCH, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_OPEN, 31, 0, 0), 1, ex(STAT_MISMATCH, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_OPEN, 0, 15, 0), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_END, 0, 0, 0), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_CLOSE, 5, 0, 0), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_END, 5, 0, 0), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_CLOSE, 0, 0, 0), 1, ex(STAT_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(KIND_CLOSE, 0, 0, 0), 1, ex(STAT_OK, 0, 0, 1)});
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].r, dir_rows[i].has_exp, dir_rows[i].e);
      idle_gap();
    end
    drain();

    // limit 2: open two entries, begin and end on them, then close them and entry 31
    write_limit(2);
    dir_rows.delete();
    dir_rows.push_back('{mk(KIND_OPEN, 1, 3, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_OPEN, 2, 3, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 1, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_END, 1, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 2, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_END, 2, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 1, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 2, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 1, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_BEGIN, 2, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_CLOSE, 1, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_CLOSE, 2, 0, 0), 0, '0});
    dir_rows.push_back('{mk(KIND_CLOSE, 31, 0, 0), 0, '0});
    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].has_exp, dir_rows[i].e);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < 200; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 1 && n == 20) fork
          begin hold_off = 1'b1; repeat (300) @(posedge clk); hold_off = 1'b0; end
        join_none
        // sender pause until every result is back
        if (n == 100) begin
          release_input();
          while (pending_rsp.size() != 0) @(posedge clk);
        end
        send_request(random_request((ph % 2) ? 8 : NENT), 0, '0);
        idle_gap();
      end
      drain();
      // lower the limit below the open count to exercise single eviction
      if (ph == 2) begin
        write_limit(1);
        for (int n = 0; n < 30; n++) send_request(random_request(NENT), 0, '0);
        drain();
      end
    end
    write_limit(63);
    drain();

    $display("Checked %0d results: %0d evictions, %0d sweep failures, limits 0..63.",
             n_rsp, n_evict, n_novict);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("handle_clock_replacement_top regression: pass");
    end else begin
      $display("handle_clock_replacement_top regression: fail");
    end
    $finish;
  end
endmodule
